FILE: hw/rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared constants for the array list engine: sizes, operation codes and
// status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

  localparam int CAPACITY      = 64;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 6;
  localparam int ENTRY_COUNT_W = 7;
  localparam int ADDR_W        = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int CMP_W         = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

endpackage

`default_nettype wire

FILE: hw/rtl/array_list_engine_unit.sv
// ----------------------------------------------------------------------------
// array_list_engine_unit
// Ordered list of signed 32-bit values held in one synchronous RAM, with an
// entry count. Requests clear, append, remove at a position, or search.
// ----------------------------------------------------------------------------
// work: clear, insert and every failed request finish in the accept cycle;
//   remove makes one RAM read per entry from the position to the end; search
//   reads one entry at a time from the start, stopping at the first match
// results pass through a finished-result register and then the output
//   register before out_valid rises
// requests: one request in the engine at a time, the next is taken once
//   the finished-result register has moved to the output register
// reset: clears the count and the handshake state; the RAM is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request channel
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire logic [1:0]                            in_operation,
  input  wire logic signed [ale_pkg::DATA_W-1:0]     in_value,
  input  wire logic [ale_pkg::POS_W-1:0]             in_position,
  // result channel
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      logic [1:0]                            out_status,
  output      logic signed [ale_pkg::DATA_W-1:0]     out_removed_value,
  output      logic                                  out_found,
  output      logic [ale_pkg::ENTRY_COUNT_W-1:0]     out_entry_count,
  output      logic                                  out_is_empty
);

  import ale_pkg::*;

  // engine states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REMOVE = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;   // address of the data arriving now
  logic              first_r, first_nxt;     // first read of a remove: the taken value
  logic [DATA_W-1:0] key_r, key_nxt;

  // finished-result register
  logic              done_r, done_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [DATA_W-1:0] res_removed_r, res_removed_nxt;
  logic              res_found_r, res_found_nxt;
  logic [CNT_W-1:0]  res_count_r, res_count_nxt;

  // output register
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [DATA_W-1:0] out_removed_r;
  logic              out_found_r;
  logic [CNT_W-1:0]  out_count_r;

  // RAM port signals
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;

  logic              in_fire;
  logic              out_load;
  logic [CNT_W-1:0]  ptr_inc;
  logic              more;

  ale_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // the engine takes a request only when idle and the finished slot is free
  assign in_ready = (state_r == S_IDLE) && !done_r;
  assign in_fire  = in_valid && in_ready;

  // finished result moves on whenever the output register is free or draining
  assign out_load = done_r && (!out_valid_r || out_ready);

  // next entry after the one whose data is arriving, and whether it exists
  assign ptr_inc = CNT_W'(rd_ptr_r) + CNT_W'(1);
  assign more    = (ptr_inc < count_r);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rd_ptr_nxt      = rd_ptr_r;
    first_nxt       = first_r;
    key_nxt         = key_r;
    done_nxt        = done_r && !out_load;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    res_found_nxt   = res_found_r;
    res_count_nxt   = res_count_r;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = rd_ptr_r;
    ram_wr_data     = ram_rd_data;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = rd_ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // default: finish at once with ok and zero payload
          done_nxt        = 1'b1;
          res_status_nxt  = ST_OK;
          res_removed_nxt = '0;
          res_found_nxt   = 1'b0;
          res_count_nxt   = count_r;
          case (in_operation)
            OP_CLEAR: begin
              count_nxt     = '0;
              res_count_nxt = '0;
            end
            OP_INSERT: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                // append at the current end of the list
                ram_wr_en     = 1'b1;
                ram_wr_addr   = ADDR_W'(count_r);
                ram_wr_data   = in_value;
                count_nxt     = count_r + CNT_W'(1);
                res_count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (CMP_W'(in_position) >= CMP_W'(count_r)) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                // fetch the entry being taken out, then shift the tail down
                done_nxt    = 1'b0;
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_W'(in_position);
                rd_ptr_nxt  = ADDR_W'(in_position);
                first_nxt   = 1'b1;
                state_nxt   = S_REMOVE;
              end
            end
            default: begin
              // search: an empty list finishes with found clear
              key_nxt = in_value;
              if (count_r != '0) begin
                done_nxt    = 1'b0;
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                rd_ptr_nxt  = '0;
                state_nxt   = S_SEARCH;
              end
            end
          endcase
        end
      end

      S_REMOVE: begin
        if (first_r) begin
          res_removed_nxt = ram_rd_data;
        end else begin
          // entry at rd_ptr moves one place down
          ram_wr_en   = 1'b1;
          ram_wr_addr = rd_ptr_r - ADDR_W'(1);
          ram_wr_data = ram_rd_data;
        end
        if (more) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ADDR_W'(ptr_inc);
          rd_ptr_nxt  = ADDR_W'(ptr_inc);
          first_nxt   = 1'b0;
        end else begin
          count_nxt      = count_r - CNT_W'(1);
          res_count_nxt  = count_r - CNT_W'(1);
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          done_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_SEARCH: begin
        if ((ram_rd_data == key_r) || !more) begin
          res_found_nxt   = (ram_rd_data == key_r);
          res_status_nxt  = ST_OK;
          res_removed_nxt = '0;
          res_count_nxt   = count_r;
          done_nxt        = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ADDR_W'(ptr_inc);
          rd_ptr_nxt  = ADDR_W'(ptr_inc);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r      <= rd_ptr_nxt;
    first_r       <= first_nxt;
    key_r         <= key_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    res_found_r   <= res_found_nxt;
    res_count_r   <= res_count_nxt;
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_removed_r <= res_removed_r;
      out_found_r   <= res_found_r;
      out_count_r   <= res_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_found         = out_found_r;
  assign out_entry_count   = ENTRY_COUNT_W'(out_count_r);
  assign out_is_empty      = (out_count_r == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/ale_ram.sv
// ----------------------------------------------------------------------------
// ale_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output      logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
